>>> design/ptp_pkg.sv
// Package for the perspective point transform: item structs, register
// reset values and pipeline depth constants. No dependencies.
`default_nettype none
package ptp_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               w_was_zero;
    logic               saturated;
  } result_t;

  localparam int NUM_REGS = 8;
  localparam int CFG_INDEX_W = 4;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  localparam int ROW_STAGES = 3;
  localparam int QUOT_BITS = 33;
  localparam int DIV_STAGES = QUOT_BITS + 2;
  localparam int LATENCY = ROW_STAGES + DIV_STAGES + 1;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

>>> design/ptp_row_mac.sv
// One matrix row: three products, the offset and a clipped Q16.16 sum.
// Three register stages. Depends on ptp_pkg.
`default_nettype none
module ptp_row_mac (
  input  wire logic               clk,
  input  wire logic signed [31:0] m0,
  input  wire logic signed [31:0] m1,
  input  wire logic signed [31:0] m2,
  input  wire logic signed [31:0] m3,
  input  wire ptp_pkg::point_t    point,
  output logic signed [31:0]      sum,
  output logic                    sat
);

  localparam logic signed [49:0] Q_MAX_W = 50'(ptp_pkg::Q_MAX);
  localparam logic signed [49:0] Q_MIN_W = 50'(ptp_pkg::Q_MIN);

  logic signed [63:0] p0, p1, p2;
  logic signed [31:0] off1;
  logic signed [64:0] s01, s2c;
  logic signed [65:0] total;
  logic signed [49:0] fl;

  assign total = 66'(s01) + 66'(s2c);
  assign fl = total[65:16];

  always_ff @(posedge clk) begin
    p0 <= m0 * point.point_x;
    p1 <= m1 * point.point_y;
    p2 <= m2 * point.point_z;
    off1 <= m3;
    s01 <= 65'(p0) + 65'(p1);
    s2c <= 65'(p2) + (65'(off1) <<< 16);
    if (fl > 50'(Q_MAX_W)) begin
      sum <= ptp_pkg::Q_MAX;
      sat <= 1'b1;
    end else if (fl < 50'(Q_MIN_W)) begin
      sum <= ptp_pkg::Q_MIN;
      sat <= 1'b1;
    end else begin
      sum <= fl[31:0];
      sat <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> design/ptp_div.sv
// Pipelined signed divider (v * 65536) / w, one quotient bit per stage,
// truncated and clipped to Q16.16. Depends on ptp_pkg.
`default_nettype none
module ptp_div (
  input  wire logic               clk,
  input  wire logic signed [31:0] v,
  input  wire logic signed [31:0] w,
  output logic signed [31:0]      quot,
  output logic                    sat
);

  localparam int QB = ptp_pkg::QUOT_BITS;

  logic [31:0] av, aw;
  logic [47:0] num;

  logic [QB:0]   rem  [QB+1];
  logic [QB-1:0] nlo  [QB+1];
  logic [QB-1:0] q    [QB+1];
  logic [31:0]   d    [QB+1];
  logic          neg  [QB+1];
  logic          big  [QB+1];

  assign av = v[31] ? (~v + 32'd1) : v;
  assign aw = w[31] ? (~w + 32'd1) : w;
  assign num = {av, 16'b0};

  always_ff @(posedge clk) begin
    rem[0] <= {{(QB+1-15){1'b0}}, num[47:33]};
    nlo[0] <= num[QB-1:0];
    q[0] <= '0;
    d[0] <= aw;
    neg[0] <= v[31] ^ w[31];
    big[0] <= {17'b0, num} >= {aw, 33'b0};
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [QB:0] t;
    logic [QB-1:0] qn;
    assign t = {rem[k-1][QB-1:0], nlo[k-1][QB-k]};
    always_comb begin
      qn = q[k-1];
      qn[QB-k] = (t >= {1'b0, d[k-1]});
    end
    always_ff @(posedge clk) begin
      rem[k] <= qn[QB-k] ? (t - {1'b0, d[k-1]}) : t;
      nlo[k] <= nlo[k-1];
      q[k] <= qn;
      d[k] <= d[k-1];
      neg[k] <= neg[k-1];
      big[k] <= big[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (big[QB]) begin
      quot <= neg[QB] ? ptp_pkg::Q_MIN : ptp_pkg::Q_MAX;
      sat <= 1'b1;
    end else if (neg[QB]) begin
      if (q[QB] > 33'h0_8000_0000) begin
        quot <= ptp_pkg::Q_MIN;
        sat <= 1'b1;
      end else begin
        quot <= 32'(~q[QB] + 33'd1);
        sat <= 1'b0;
      end
    end else begin
      if (q[QB] > 33'h0_7FFF_FFFF) begin
        quot <= ptp_pkg::Q_MAX;
        sat <= 1'b1;
      end else begin
        quot <= q[QB][31:0];
        sat <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/point_transform_perspective.sv
// Top level of the perspective point transform: matrix registers, four
// row units, three divider lanes. Depends on ptp_pkg, ptp_row_mac, ptp_div.
//
//   channel   handshake              payload
//   point     start / busy           point  (ptp_pkg::point_t)
//   result    done strobe            result (ptp_pkg::result_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted every cycle; busy is high only during reset.
// Each result follows its item through three row stages, the divider's entry
// stage, 33 quotient stages, its exit stage and the output register.
// Reset loads the matrix from ptp_pkg::REG_RESET and empties the pipeline.
// There are no stalls: the pipeline advances every cycle.
`default_nettype none
module point_transform_perspective (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ptp_pkg::point_t                   point,
  output logic                                   done,
  output ptp_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ptp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [63:0]                       cfg_data
);

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               wz;
    logic               sat;
  } ctl_t;

  localparam int DS = ptp_pkg::DIV_STAGES;
  localparam int RS = ptp_pkg::ROW_STAGES;

  logic [63:0] regs [ptp_pkg::NUM_REGS];
  logic signed [31:0] rsum [4];
  logic rsat [4];
  logic signed [31:0] dq [3];
  logic dsat [3];
  logic [RS+DS-1:0] vld;
  ctl_t ctl [DS];

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptp_pkg::NUM_REGS; i++) regs[i] <= ptp_pkg::REG_RESET[i];
    end else if (cfg_valid && cfg_index < ptp_pkg::CFG_INDEX_W'(ptp_pkg::NUM_REGS)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    ptp_row_mac u_row (
      .clk  (clk),
      .m0   (regs[2*r][31:0]),
      .m1   (regs[2*r][63:32]),
      .m2   (regs[2*r+1][31:0]),
      .m3   (regs[2*r+1][63:32]),
      .point(point),
      .sum  (rsum[r]),
      .sat  (rsat[r])
    );
  end

  for (genvar l = 0; l < 3; l++) begin : g_div
    ptp_div u_div (
      .clk (clk),
      .v   (rsum[l]),
      .w   (rsum[3]),
      .quot(dq[l]),
      .sat (dsat[l])
    );
  end

  always_ff @(posedge clk) begin
    ctl[0] <= '{vx: rsum[0], vy: rsum[1], vz: rsum[2], wz: (rsum[3] == 32'sd0),
                sat: rsat[0] | rsat[1] | rsat[2] | rsat[3]};
    for (int i = 1; i < DS; i++) ctl[i] <= ctl[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[RS+DS-2:0], start & ~busy};
      done <= vld[RS+DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[DS-1].wz) begin
      result <= '{result_x: ctl[DS-1].vx, result_y: ctl[DS-1].vy,
                  result_z: ctl[DS-1].vz, w_was_zero: 1'b1, saturated: ctl[DS-1].sat};
    end else begin
      result <= '{result_x: dq[0], result_y: dq[1], result_z: dq[2], w_was_zero: 1'b0,
                  saturated: ctl[DS-1].sat | dsat[0] | dsat[1] | dsat[2]};
    end
  end

endmodule
`default_nettype wire

>>> design/ptp_checker.sv
// Port-level checker for the perspective point transform, bound to the
// top level. Depends on ptp_pkg.
`default_nettype none
module ptp_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire logic             cfg_ready
);

  localparam int LAT = ptp_pkg::LATENCY;

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("Result strobe without an accepted item.");

  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("Accepted item produced no result.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !done)
    else $error("Result strobe right after reset.");

  a_ready_out_of_reset: assert property (@(posedge clk)
    !rst |-> (!busy && cfg_ready))
    else $error("Block not ready outside reset.");

endmodule

bind point_transform_perspective ptp_checker u_ptp_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .cfg_ready(cfg_ready)
);
`default_nettype wire
